/* rtl/quick_texture_hash_core_defines.svh */
// Assertion macros shared by the quick texture hash RTL.
// Needs clk and rst_n in the scope of each use; no other dependencies.
`ifndef QUICK_TEXTURE_HASH_CORE_DEFINES_SVH
`define QUICK_TEXTURE_HASH_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define QTH_ASSERT_PROP(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("quick texture hash: property violated");
`define QTH_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("quick texture hash: forbidden condition seen");
`else
`define QTH_ASSERT_PROP(label, prop)
`define QTH_ASSERT_NEVER(label, cond)
`endif
`endif

/* rtl/qth_pkg.sv */
// Shared types, constants and halfword arithmetic for the quick texture hash.
// No dependencies; used by qth_datapath and quick_texture_hash_core.
package qth_pkg;

    localparam int unsigned QTH_MAX_BYTES = 8388608;
    localparam int unsigned QTH_ADDR_W    = 32;
    localparam int unsigned QTH_LEN_W     = 24;
    localparam int unsigned QTH_WORD_W    = 32;
    localparam int unsigned QTH_SLOT_W    = 4;
    localparam int unsigned QTH_LANES     = 4;

    localparam logic [31:0] QTH_FACTOR_STEP = 32'h2455_2455;
    localparam logic [31:0] QTH_INIT_FACTOR [QTH_LANES] = '{
        32'h9bd9_c00b, 32'hb651_4b73, 32'h4309_4d9b, 32'h0001_0083
    };

    // Control from the stream handling into the hash state.
    typedef struct packed {
        logic step;   // take the word into the hash state this cycle
        logic first;  // the word opens a new buffer
    } qth_ctrl_t;

    // Multiply each 16-bit half separately, keeping the low 16 bits of each product.
    function automatic logic [31:0] mul_halves(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] prod_lo;
        logic [31:0] prod_hi;
        prod_lo = 32'(a[15:0]) * 32'(b[15:0]);
        prod_hi = 32'(a[31:16]) * 32'(b[31:16]);
        return {prod_hi[15:0], prod_lo[15:0]};
    endfunction

    // Add each 16-bit half separately, modulo 2^16.
    function automatic logic [31:0] halfword_sum(input logic [31:0] a, input logic [31:0] b);
        logic [15:0] sum_lo;
        logic [15:0] sum_hi;
        sum_lo = a[15:0] + b[15:0];
        sum_hi = a[31:16] + b[31:16];
        return {sum_hi, sum_lo};
    endfunction

endpackage

/* rtl/quick_texture_hash_core.sv */
// Quick texture hash over a buffer streamed as little-endian 32-bit words.
// Slave side: one item per buffer word; tuser marks the first word of a buffer,
// which also carries the start address and byte length, and tlast marks the
// word after which the hash is wanted. A zero-length buffer is one dummy word.
// Master side: one item per tlast word, holding the 32-bit hash.
// Throughput is one word per cycle while the receiver keeps up: the word is
// registered on acceptance, goes through the halfword multiply/add lane update
// into the hash state, and the hash is summed from the four lanes into the
// output register. When the receiver stalls, the finished hash waits in the
// output register and one further hash waits behind it in the hash state; only
// when a word then waits in the input register does s_tready drop, so no word
// moves the hash state while a result is still to be read from it.
// Reset clears the lanes to the initial factors, empties all stages and leaves
// no buffer bytes outstanding, so words that arrive without a first word are
// ignored. Depends on qth_pkg, qth_datapath and the defines header.
`include "quick_texture_hash_core_defines.svh"

module quick_texture_hash_core #(
    parameter int unsigned MAX_BYTES = qth_pkg::QTH_MAX_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // start_address[31:0], byte_length[55:32], data_word[87:56]
    input  logic        s_tlast,
    input  logic [0:0]  s_tuser,   // first[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // hash[31:0]
);
    import qth_pkg::*;

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic                  in_first_reg;
    logic                  in_last_reg;
    logic [QTH_ADDR_W-1:0] in_addr_reg;
    logic [QTH_LEN_W-1:0]  in_len_reg;
    logic [QTH_WORD_W-1:0] in_word_reg;

    logic                  pending_reg;
    logic                  pending_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [31:0]           hash_reg;

    logic                  advance;
    logic                  pend_move;
    qth_ctrl_t             ctrl;
    logic [31:0]           hash_value;

    // The pending hash is read from the state, so no word may step it meanwhile.
    assign pend_move = pending_reg && (!out_valid_reg || m_tready);
    assign advance   = in_valid_reg && (!pending_reg || pend_move);
    assign s_tready  = !in_valid_reg || advance;

    assign in_valid_next  = s_tvalid || (in_valid_reg && !advance);
    assign pending_next   = (advance && in_last_reg) || (pending_reg && !pend_move);
    assign out_valid_next = pend_move || (out_valid_reg && !m_tready);

    assign ctrl.step  = advance;
    assign ctrl.first = in_first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= in_valid_next;
            end
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_first_reg <= s_tuser[0];
            in_last_reg  <= s_tlast;
            in_addr_reg  <= s_tdata[31:0];
            in_len_reg   <= s_tdata[55:32];
            in_word_reg  <= s_tdata[87:56];
        end
        if (pend_move)
        begin
            hash_reg <= hash_value;
        end
    end

    qth_datapath #(
        .MAX_BYTES(MAX_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .start_address(in_addr_reg),
        .byte_length  (in_len_reg),
        .data_word    (in_word_reg),
        .hash_value   (hash_value)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = hash_reg;

    `QTH_ASSERT_PROP(a_last_sets_pending, (advance && in_last_reg) |=> pending_reg)
    `QTH_ASSERT_NEVER(a_no_step_over_pending, advance && pending_reg && !pend_move)
    `QTH_ASSERT_PROP(a_out_from_pending, $rose(out_valid_reg) |-> $past(pending_reg))
    `QTH_ASSERT_PROP(a_pending_waits, (pending_reg && !pend_move) |=> pending_reg)
    `QTH_ASSERT_PROP(a_empty_input_ready, !in_valid_reg |-> s_tready)

endmodule

/* rtl/qth_datapath.sv */
// Hash state and per-word update of the quick texture hash: four lanes for the
// aligned block hash and a pairwise sum for the fallback. Depends on qth_pkg.
module qth_datapath #(
    parameter int unsigned MAX_BYTES = qth_pkg::QTH_MAX_BYTES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  qth_pkg::qth_ctrl_t               ctrl,
    input  logic [qth_pkg::QTH_ADDR_W-1:0]   start_address,
    input  logic [qth_pkg::QTH_LEN_W-1:0]    byte_length,
    input  logic [qth_pkg::QTH_WORD_W-1:0]   data_word,
    output logic [31:0]                      hash_value
);
    import qth_pkg::*;

    localparam logic [QTH_LEN_W-1:0] MAX_LEN = QTH_LEN_W'(MAX_BYTES);

    localparam logic [1:0] GROUP_MULADD = 2'd0;
    localparam logic [1:0] GROUP_XOR    = 2'd1;
    localparam logic [1:0] GROUP_ADD    = 2'd2;
    localparam logic [1:0] GROUP_CLOSE  = 2'd3;

    logic [31:0]           lane_sum_reg     [QTH_LANES];
    logic [31:0]           lane_factor_reg  [QTH_LANES];
    logic [31:0]           lane_partial_reg [QTH_LANES];
    logic [QTH_SLOT_W-1:0] word_slot_reg;
    logic [31:0]           fallback_sum_reg;
    logic [31:0]           held_word_reg;
    logic                  fallback_mode_reg;
    logic [QTH_LEN_W-1:0]  bytes_left_reg;

    logic [31:0]           lane_sum_next     [QTH_LANES];
    logic [31:0]           lane_factor_next  [QTH_LANES];
    logic [31:0]           lane_partial_next [QTH_LANES];
    logic [QTH_SLOT_W-1:0] word_slot_next;
    logic [31:0]           fallback_sum_next;
    logic [31:0]           held_word_next;
    logic                  fallback_mode_next;
    logic [QTH_LEN_W-1:0]  bytes_left_next;

    logic [QTH_LEN_W-1:0]  len_clamped;
    logic [1:0]            lane;
    logic [1:0]            group;
    logic [31:0]           mul_res;

    assign len_clamped = (byte_length > MAX_LEN) ? MAX_LEN : byte_length;

    always_comb
    begin
        // A first word starts from the cleared state, then is taken in as data.
        for (int i = 0; i < QTH_LANES; i++)
        begin
            lane_sum_next[i]     = ctrl.first ? 32'd0 : lane_sum_reg[i];
            lane_factor_next[i]  = ctrl.first ? QTH_INIT_FACTOR[i] : lane_factor_reg[i];
            lane_partial_next[i] = ctrl.first ? 32'd0 : lane_partial_reg[i];
        end
        word_slot_next     = ctrl.first ? '0 : word_slot_reg;
        fallback_sum_next  = ctrl.first ? 32'd0 : fallback_sum_reg;
        held_word_next     = ctrl.first ? 32'd0 : held_word_reg;
        fallback_mode_next = ctrl.first ? ((start_address[3:0] != 4'd0) ||
                                           (len_clamped[5:0] != 6'd0))
                                        : fallback_mode_reg;
        bytes_left_next    = ctrl.first ? len_clamped : bytes_left_reg;

        lane    = word_slot_next[1:0];
        group   = word_slot_next[3:2];
        mul_res = mul_halves(data_word, lane_factor_next[lane]);

        // Only whole words of the buffer count; anything past its end is dropped.
        if (bytes_left_next[QTH_LEN_W-1:2] != '0)
        begin
            if (fallback_mode_next)
            begin
                if (!word_slot_next[0])
                begin
                    held_word_next = data_word;
                end
                else
                begin
                    fallback_sum_next = (fallback_sum_next + held_word_next) ^ data_word;
                end
            end
            else
            begin
                case (group)
                    GROUP_MULADD:
                    begin
                        lane_partial_next[lane] = halfword_sum(lane_sum_next[lane], mul_res);
                    end
                    GROUP_XOR:
                    begin
                        lane_partial_next[lane] = lane_partial_next[lane] ^ data_word;
                    end
                    GROUP_ADD:
                    begin
                        lane_partial_next[lane] = lane_partial_next[lane] + data_word;
                    end
                    GROUP_CLOSE:
                    begin
                        lane_sum_next[lane]    = lane_partial_next[lane] ^ mul_res;
                        lane_factor_next[lane] = halfword_sum(lane_factor_next[lane],
                                                              QTH_FACTOR_STEP);
                    end
                    default:
                    begin
                        lane_sum_next[lane] = lane_sum_next[lane];
                    end
                endcase
            end
            word_slot_next  = word_slot_next + QTH_SLOT_W'(1);
            bytes_left_next = bytes_left_next - QTH_LEN_W'(4);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QTH_LANES; i++)
            begin
                lane_sum_reg[i]     <= 32'd0;
                lane_factor_reg[i]  <= QTH_INIT_FACTOR[i];
                lane_partial_reg[i] <= 32'd0;
            end
            word_slot_reg     <= '0;
            fallback_sum_reg  <= 32'd0;
            held_word_reg     <= 32'd0;
            fallback_mode_reg <= 1'b0;
            bytes_left_reg    <= '0;
        end
        else if (ctrl.step)
        begin
            for (int i = 0; i < QTH_LANES; i++)
            begin
                lane_sum_reg[i]     <= lane_sum_next[i];
                lane_factor_reg[i]  <= lane_factor_next[i];
                lane_partial_reg[i] <= lane_partial_next[i];
            end
            word_slot_reg     <= word_slot_next;
            fallback_sum_reg  <= fallback_sum_next;
            held_word_reg     <= held_word_next;
            fallback_mode_reg <= fallback_mode_next;
            bytes_left_reg    <= bytes_left_next;
        end
    end

    // The hash is read from the settled state, once the last word has been taken in.
    always_comb
    begin
        logic [31:0] pair_a;
        logic [31:0] pair_b;
        pair_a = (lane_sum_reg[0] + lane_factor_reg[0]) + (lane_sum_reg[1] + lane_factor_reg[1]);
        pair_b = (lane_sum_reg[2] + lane_factor_reg[2]) + (lane_sum_reg[3] + lane_factor_reg[3]);
        hash_value = fallback_mode_reg ? fallback_sum_reg : (pair_a + pair_b);
    end

endmodule

/* tb/quick_texture_hash_core_tb.sv */
// Self-checking testbench for quick_texture_hash_core: streams texture buffers in
// block-hash and fallback modes under several pacing phases and checks every hash.
// Depends on qth_pkg and the quick_texture_hash_core RTL.
module quick_texture_hash_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qth_pkg::*;

    typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} pace_t;

    typedef struct {
        bit          first;
        bit          last;
        logic [31:0] addr;
        logic [23:0] len;
        logic [31:0] word;
        pace_t       pace;
        bit          drain;
    } tex_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;   // start_address[31:0], byte_length[55:32], data_word[87:56]
    logic        s_tlast = 1'b0;
    logic [0:0]  s_tuser = '0;   // first[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // hash[31:0]

    quick_texture_hash_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    tex_word_t   pending_words [$];
    logic [31:0] hash_expected [$];
    tex_word_t   on_bus;
    pace_t       cur_pace = PH_FREE;
    pace_t       gen_pace = PH_FREE;
    bit          gen_drain = 1'b0;
    int          words_queued = 0;
    int          words_accepted = 0;
    int          buffers_queued = 0;
    int          hashes_checked = 0;
    int          mismatches = 0;

    // Predicted hash state.
    logic [31:0] lane_acc [QTH_LANES];
    logic [31:0] lane_mul [QTH_LANES];
    logic [31:0] lane_tmp [QTH_LANES];
    logic [3:0]  blk_pos;
    logic [31:0] pair_acc;
    logic [31:0] pair_head;
    bit          pair_mode;
    logic [23:0] bytes_due;

    function automatic logic [31:0] half_mul(logic [31:0] a, logic [31:0] b);
        return {16'(a[31:16] * b[31:16]), 16'(a[15:0] * b[15:0])};
    endfunction

    function automatic logic [31:0] half_add(logic [31:0] a, logic [31:0] b);
        return {16'(a[31:16] + b[31:16]), 16'(a[15:0] + b[15:0])};
    endfunction

    task automatic restart_hash();
        for (int i = 0; i < QTH_LANES; i++)
        begin
            lane_acc[i] = '0;
            lane_mul[i] = QTH_INIT_FACTOR[i];
            lane_tmp[i] = '0;
        end
        blk_pos   = '0;
        pair_acc  = '0;
        pair_head = '0;
        pair_mode = 1'b0;
        bytes_due = '0;
    endtask

    task automatic absorb_word(input tex_word_t w, output bit has_hash,
                               output logic [31:0] hash_val);
        logic [23:0] len;
        int          lane;
        len = w.len;
        if (w.first)
        begin
            restart_hash();
            if (len > QTH_MAX_BYTES)
                len = 24'(QTH_MAX_BYTES);
            pair_mode = (w.addr[3:0] != 4'h0) || (len[5:0] != 6'h0);
            bytes_due = len;
        end
        // A word with fewer than four buffer bytes left adds nothing to the hash; its last flag still counts.
        if (bytes_due >= 24'd4)
        begin
            if (pair_mode)
            begin
                if (!blk_pos[0])
                    pair_head = w.word;
                else
                    pair_acc = (pair_acc + pair_head) ^ w.word;
            end
            else
            begin
                lane = int'(blk_pos[1:0]);
                case (blk_pos[3:2])
                    2'd0: lane_tmp[lane] = half_add(lane_acc[lane],
                                                    half_mul(w.word, lane_mul[lane]));
                    2'd1: lane_tmp[lane] = lane_tmp[lane] ^ w.word;
                    2'd2: lane_tmp[lane] = lane_tmp[lane] + w.word;
                    default:
                    begin
                        lane_acc[lane] = lane_tmp[lane] ^ half_mul(w.word, lane_mul[lane]);
                        lane_mul[lane] = half_add(lane_mul[lane], QTH_FACTOR_STEP);
                    end
                endcase
            end
            blk_pos   = blk_pos + 4'd1;
            bytes_due = bytes_due - 24'd4;
        end
        has_hash = w.last;
        if (pair_mode)
            hash_val = pair_acc;
        else
        begin
            hash_val = '0;
            for (int i = 0; i < QTH_LANES; i++)
                hash_val = hash_val + lane_acc[i] + lane_mul[i];
        end
    endtask

    function automatic int idle_pct(pace_t p, bit receiver);
        case (p)
            PH_SEND_IDLE:  return receiver ? 0 : 73;
            PH_RECV_STALL: return receiver ? 73 : 0;
            PH_BOTH:       return 15;
            default:       return 0;
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic int words_for(logic [23:0] len);
        return (len == 24'd0) ? 1 : (int'(len) + 3) / 4;
    endfunction

    task automatic queue_word(bit first, bit last, logic [31:0] addr, logic [23:0] len,
                              logic [31:0] word);
        pending_words.push_back('{first, last, addr, len, word, gen_pace, gen_drain});
        gen_drain = 1'b0;
        words_queued++;
        if (first)
            buffers_queued++;
    endtask

    // Address and length fields of the words after the first carry noise.
    task automatic queue_buffer(logic [31:0] addr, logic [23:0] len, int nwords);
        for (int i = 0; i < nwords; i++)
            queue_word(i == 0, i == nwords - 1, (i == 0) ? addr : $urandom,
                       (i == 0) ? len : 24'($urandom), rand_word());
    endtask

    // Driver: presents queued items and predicts each one as it is accepted.
    always @(posedge clk)
    begin
        bit          got_hash;
        logic [31:0] hash_val;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                absorb_word(on_bus, got_hash, hash_val);
                if (got_hash)
                    hash_expected.push_back(hash_val);
                words_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_words.size() != 0
                    && !(pending_words[0].drain && hash_expected.size() != 0)
                    && $urandom_range(99) >= idle_pct(pending_words[0].pace, 1'b0))
                begin
                    on_bus = pending_words.pop_front();
                    cur_pace = on_bus.pace;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {on_bus.word, on_bus.len, on_bus.addr};
                    s_tlast  <= on_bus.last;
                    s_tuser  <= on_bus.first;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each hash against the oldest prediction.
    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (hash_expected.size() == 0)
                begin
                    $display("%0t: unexpected hash: expected none, actual %h", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = hash_expected.pop_front();
                    hashes_checked++;
                    if (m_tdata !== want)
                    begin
                        $display("%0t: hash mismatch: expected %h, actual %h",
                                 $time, want, m_tdata);
                        mismatches++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= idle_pct(cur_pace, 1'b1));
        end
    end

    initial
    begin
        logic [31:0] addr;
        logic [23:0] len;
        int          pick;
        int          nblk;
        int          nword;
        int          target;

        restart_hash();

        // Words with no first straight after reset are ignored; the last gives the
        // reset-state block hash.
        queue_word(1'b0, 1'b0, $urandom, 24'($urandom), rand_word());
        queue_word(1'b0, 1'b1, $urandom, 24'($urandom), rand_word());
        // Zero length, aligned and unaligned.
        queue_word(1'b1, 1'b1, 32'h0000_0000, 24'd0, rand_word());
        queue_word(1'b1, 1'b1, 32'hffff_ffff, 24'd0, rand_word());
        // One full block of all-ones data at the top aligned address.
        for (int i = 0; i < 16; i++)
            queue_word(i == 0, i == 15, 32'hffff_fff0, 24'd64, 32'hffff_ffff);
        // Fallback with tail bytes: the third word holds only two tail bytes and is dropped.
        queue_buffer(32'h0000_0010, 24'd10, 3);
        // Maximum length field is cut to the limit; the early last takes two words.
        queue_buffer(32'h0000_0000, 24'hff_ffff, 2);

        target = words_queued;
        for (int p = 0; p < 4; p++)
        begin
            gen_pace  = pace_t'(p);
            gen_drain = 1'b1;
            target    = target + 400;
            while (words_queued < target)
            begin
                pick = $urandom_range(99);
                if (pick < 45)
                begin
                    nblk = ($urandom_range(9) == 0) ? $urandom_range(16, 4) : $urandom_range(3, 1);
                    addr = $urandom & ~32'hf;
                    len  = 24'(nblk * 64);
                    queue_buffer(addr, len, words_for(len));
                end
                else if (pick < 75)
                begin
                    addr = $urandom;
                    if ($urandom_range(1))
                        addr[3:0] = 4'h0;
                    len = 24'($urandom_range(200));
                    queue_buffer(addr, len, words_for(len));
                end
                else if (pick < 87)
                begin
                    // Last arrives early or after words past the length.
                    addr = $urandom;
                    if ($urandom_range(2) != 0)
                        addr[3:0] = 4'h0;
                    len = 24'(64 * $urandom_range(4));
                    if ($urandom_range(1))
                        len = len + 24'($urandom_range(63));
                    queue_buffer(addr, len, $urandom_range(words_for(len) + 4, 1));
                end
                else if (pick < 93)
                begin
                    addr = $urandom;
                    if ($urandom_range(1))
                        addr[3:0] = 4'h0;
                    len = 24'($urandom_range(24'hff_ffff, QTH_MAX_BYTES - 64));
                    queue_buffer(addr, len, $urandom_range(24, 1));
                end
                else
                begin
                    nword = $urandom_range(6, 1);
                    for (int i = 0; i < nword; i++)
                        queue_word(1'b0, i == nword - 1, $urandom, 24'($urandom), rand_word());
                end
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (words_accepted < words_queued || hash_expected.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Streamed %0d buffers in %0d words across four pacing phases; %0d hashes checked.",
                 buffers_queued, words_accepted, hashes_checked);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Timed out waiting for the stream to finish.");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/qth_pkg.sv
rtl/qth_datapath.sv
rtl/quick_texture_hash_core.sv
tb/quick_texture_hash_core_tb.sv
